>>> rtl/core/secded_pkg.sv
// Shared types, constants and functions for the 64-bit SEC-DED encode/check core.
// No dependencies; every other file of the core imports this package.
`default_nettype none

package secded_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned CHECK_W = 8;
  localparam int unsigned NUM_PAR = 6;
  localparam int unsigned HIT_W   = 6;

  localparam logic [DATA_W-1:0] PAR_MASK [NUM_PAR] = '{
    64'h5555555555555555, 64'h3333333333333333, 64'h0F0F0F0F0F0F0F0F,
    64'h00FF00FF00FF00FF, 64'h0000FFFF0000FFFF, 64'h00000000FFFFFFFF
  };

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_CHECK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CLS_CLEAN   = 2'd0,
    CLS_CHKBIT  = 2'd1,
    CLS_DATABIT = 2'd2,
    CLS_UNCORR  = 2'd3
  } cls_e;

  // After the parity trees.
  typedef struct packed {
    op_e                  op;
    logic [DATA_W-1:0]    data;
    logic [CHECK_W-1:0]   check_in;
    logic [NUM_PAR-1:0]   mpar;
    logic                 dpar;
  } s1_t;

  // After the check byte and the syndrome are formed.
  typedef struct packed {
    op_e                  op;
    logic [DATA_W-1:0]    data;
    logic [CHECK_W-1:0]   calc;
    logic [CHECK_W-1:0]   diff;
  } s2_t;

  // After the syndrome is classified.
  typedef struct packed {
    cls_e                 cls;
    logic [HIT_W-1:0]     hit;
    logic [DATA_W-1:0]    data;
    logic [CHECK_W-1:0]   calc;
  } s3_t;

  function automatic logic [CHECK_W-1:0] encode_byte(input logic [DATA_W-1:0] d);
    logic [NUM_PAR:0] ham;
    ham[NUM_PAR] = d[DATA_W-1];
    for (int j = 0; j < NUM_PAR; j++) begin
      ham[j] = ^(d & PAR_MASK[j]);
    end
    return {ham, (^d) ^ (^ham[NUM_PAR-1:0])};
  endfunction

  // Check byte of a word that has only bit i set.
  function automatic logic [CHECK_W-1:0] data_bit_code(input int i);
    return encode_byte(DATA_W'(1) << i);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/secded_in_if.sv
// Input channel of the SEC-DED core: operation, data word and stored check byte.
// Depends on secded_pkg.
`default_nettype none

interface secded_in_if;
  import secded_pkg::*;

  logic                valid;
  logic                ready;
  logic                op;
  logic [DATA_W-1:0]   data_word;
  logic [CHECK_W-1:0]  check_in;

  modport source (output valid, output op, output data_word, output check_in, input ready);
  modport sink   (input valid, input op, input data_word, input check_in, output ready);
endinterface

`default_nettype wire

>>> rtl/core/secded_out_if.sv
// Output channel of the SEC-DED core: corrected word, check byte and status flags.
// Depends on secded_pkg.
`default_nettype none

interface secded_out_if;
  import secded_pkg::*;

  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   data_out;
  logic [CHECK_W-1:0]  check_out;
  logic                fixed;
  logic                status;
  logic                fault_seen;

  modport source (output valid, output data_out, output check_out, output fixed,
                  output status, output fault_seen, input ready);
  modport sink   (input valid, input data_out, input check_out, input fixed,
                  input status, input fault_seen, output ready);
endinterface

`default_nettype wire

>>> rtl/core/secded_syndrome.sv
// First two pipeline stages: mask parity trees, then check byte and syndrome.
// Depends on secded_pkg and secded_in_if.
`default_nettype none

module secded_syndrome (
  input  logic              clk,
  input  logic              rst,
  secded_in_if.sink         req,
  output logic              s2_valid,
  input  logic              s2_ready,
  output secded_pkg::s2_t   s2
);
  import secded_pkg::*;

  logic               s1_valid;
  s1_t                s1;
  logic               s1_en;
  logic               s2_en;
  s1_t                s1_next;
  s2_t                s2_next;
  logic [NUM_PAR:0]   ham;

  // Each stage loads when it is empty or its word moves on.
  assign s2_en     = !s2_valid || s2_ready;
  assign s1_en     = !s1_valid || s2_en;
  assign req.ready = s1_en;

  always_comb begin
    s1_next.op       = op_e'(req.op);
    s1_next.data     = req.data_word;
    s1_next.check_in = req.check_in;
    s1_next.dpar     = ^req.data_word;
    for (int j = 0; j < NUM_PAR; j++) begin
      s1_next.mpar[j] = ^(req.data_word & PAR_MASK[j]);
    end
  end

  always_comb begin
    ham          = {s1.data[DATA_W-1], s1.mpar};
    s2_next.op   = s1.op;
    s2_next.data = s1.data;
    s2_next.calc = {ham, s1.dpar ^ (^s1.mpar)};
    s2_next.diff = s2_next.calc ^ s1.check_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_en) s1_valid <= req.valid;
      if (s2_en) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && req.valid) s1 <= s1_next;
    if (s2_en && s1_valid) s2 <= s2_next;
  end

endmodule

`default_nettype wire

>>> rtl/core/secded_decode.sv
// Last two pipeline stages: syndrome classification, then correction, sticky
// fault flag and output register. Depends on secded_pkg and secded_out_if.
`default_nettype none

module secded_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              s2_valid,
  output logic              s2_ready,
  input  secded_pkg::s2_t   s2,
  secded_out_if.source      rsp
);
  import secded_pkg::*;

  logic               s3_valid;
  s3_t                s3;
  s3_t                s3_next;
  logic               s3_en;
  logic               out_en;
  logic               found;
  logic [HIT_W-1:0]   hit;
  logic               fault_sticky;
  logic               fault_sticky_next;
  logic [DATA_W-1:0]  data_next;

  assign out_en   = !rsp.valid || rsp.ready;
  assign s3_en    = !s3_valid || out_en;
  assign s2_ready = s3_en;

  // Compare the syndrome against every single data bit code; the ascending
  // scan lets the highest matching bit win.
  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (data_bit_code(i) == s2.diff) begin
        found = 1'b1;
        hit   = HIT_W'(i);
      end
    end
  end

  always_comb begin
    s3_next.hit  = hit;
    s3_next.data = s2.data;
    s3_next.calc = s2.calc;
    priority if (s2.op == OP_ENCODE || s2.diff == '0) begin
      s3_next.cls = CLS_CLEAN;
    end else if ((s2.diff & (s2.diff - CHECK_W'(1))) == '0) begin
      s3_next.cls = CLS_CHKBIT;
    end else if (found) begin
      s3_next.cls = CLS_DATABIT;
    end else begin
      s3_next.cls = CLS_UNCORR;
    end
  end

  always_comb begin
    fault_sticky_next = fault_sticky || (s3.cls == CLS_UNCORR);
    unique case (s3.cls)
      CLS_DATABIT: data_next = s3.data ^ (DATA_W'(1) << s3.hit);
      CLS_UNCORR:  data_next = '0;
      default:     data_next = s3.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid     <= 1'b0;
      rsp.valid    <= 1'b0;
      fault_sticky <= 1'b0;
    end else begin
      if (s3_en) s3_valid <= s2_valid;
      if (out_en) rsp.valid <= s3_valid;
      if (out_en && s3_valid) fault_sticky <= fault_sticky_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && s2_valid) s3 <= s3_next;
    if (out_en && s3_valid) begin
      rsp.data_out   <= data_next;
      rsp.check_out  <= s3.calc;
      rsp.fixed      <= (s3.cls == CLS_CHKBIT) || (s3.cls == CLS_DATABIT);
      rsp.status     <= (s3.cls == CLS_UNCORR);
      rsp.fault_seen <= fault_sticky_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/secded_64bit_encode_check_core.sv
// SEC-DED (72,64) encode and check-with-correction core, four register stages.
// A word passes s1, s2, s3 and the output register on its way from req to rsp.
// Throughput: one word per cycle unless rsp stalls; stages advance independently, so
// bubbles fill while the output register waits and a stall drops or repeats nothing.
// Reset (rst, synchronous) empties the pipeline and clears the sticky fault flag.
// Depends on secded_pkg, secded_in_if, secded_out_if, secded_syndrome, secded_decode.
`default_nettype none

module secded_64bit_encode_check_core (
  input  logic         clk,
  input  logic         rst,
  secded_in_if.sink    req,
  secded_out_if.source rsp
);
  import secded_pkg::*;

  logic  s2_valid;
  logic  s2_ready;
  s2_t   s2;

  secded_syndrome u_syndrome (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2)
  );

  secded_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2),
    .rsp      (rsp)
  );

  a_fix_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.fixed && rsp.status))
    else $error("fixed and status both set on one word");

  a_uncorr_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |-> (rsp.data_out == '0))
    else $error("uncorrectable word does not read as zero");

  a_uncorr_sticky: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |-> rsp.fault_seen)
    else $error("uncorrectable word without sticky fault");

  a_sticky_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && rsp.fault_seen) ##1 rsp.valid |-> rsp.fault_seen)
    else $error("sticky fault flag cleared without reset");

endmodule

`default_nettype wire

>>> tb/sv/secded_64bit_encode_check_checker.sv
`timescale 1ns / 100ps
// Checker for the 64-bit SEC-DED encode/check core: watches both channels,
// predicts every result word on its own and compares it field by field.
// Depends on secded_pkg, secded_in_if and secded_out_if.

module secded_64bit_encode_check_checker
  import secded_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  secded_in_if   req,
  secded_out_if  rsp,
  output int     fail_count,
  output int     open_count
);

  typedef struct {
    logic [DATA_W-1:0]  data;
    logic [CHECK_W-1:0] check;
    logic               fixed;
    logic               status;
    logic               fault;
  } ecc_result_t;

  ecc_result_t  result_q[$];
  logic         fault_latched;

  // Mask j of the parity trees covers the bit positions whose index has bit j clear.
  function automatic logic [CHECK_W-1:0] code_of(input logic [DATA_W-1:0] w);
    logic [6:0] h;
    h = '0;
    for (int i = 0; i < 64; i++) begin
      if (w[i]) begin
        for (int j = 0; j < 6; j++) begin
          if (!i[j]) h[j] = ~h[j];
        end
      end
    end
    h[6] = w[63];
    return {h, (^w) ^ (^h[5:0])};
  endfunction

  function automatic ecc_result_t correct_word(input op_e op, input logic [DATA_W-1:0] w,
                                               input logic [CHECK_W-1:0] stored);
    ecc_result_t        r;
    logic [CHECK_W-1:0] syn;
    int                 flip_pos;
    r.data   = w;
    r.check  = code_of(w);
    r.fixed  = 1'b0;
    r.status = 1'b0;
    syn      = r.check ^ stored;
    flip_pos = -1;
    if (op == OP_CHECK && syn != '0) begin
      if ((syn & (syn - 1'b1)) == '0) begin
        // A single check bit is off, or a data bit whose code aliases one.
        r.fixed = 1'b1;
      end else begin
        for (int i = 0; i < 64; i++) begin
          if (code_of(64'd1 << i) == syn) flip_pos = i;
        end
        if (flip_pos >= 0) begin
          r.data[flip_pos] = ~r.data[flip_pos];
          r.fixed = 1'b1;
        end else begin
          r.data        = '0;
          r.status      = 1'b1;
          fault_latched = 1'b1;
        end
      end
    end
    r.fault = fault_latched;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    open_count = 0;
  end

  always @(posedge clk) begin
    ecc_result_t want;
    if (rst) begin
      fault_latched = 1'b0;
      result_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result word with none expected, actual data %h", $time,
                   rsp.data_out);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          compare_field("data_out", want.data, rsp.data_out);
          compare_field("check_out", 64'(want.check), 64'(rsp.check_out));
          compare_field("fixed", 64'(want.fixed), 64'(rsp.fixed));
          compare_field("status", 64'(want.status), 64'(rsp.status));
          compare_field("fault_seen", 64'(want.fault), 64'(rsp.fault_seen));
        end
      end
      if (req.valid && req.ready) begin
        result_q.push_back(correct_word(op_e'(req.op), req.data_word, req.check_in));
      end
    end
    open_count <= result_q.size();
  end

endmodule

>>> tb/sv/secded_64bit_encode_check_core_test.sv
`timescale 1ns / 100ps
// Top of the SEC-DED core test: clock, reset, word stimulus and the verdict.
// Depends on secded_pkg, both channel interfaces, the core and its checker.

module secded_64bit_encode_check_core_test;
  import secded_pkg::*;

  localparam int CycleLimit = 100000;
  localparam int RandomWords = 500;

  logic clk;
  logic rst;
  int   cycle_count;
  int   words_sent;
  int   fail_count;
  int   open_count;
  int   hold_left;
  bit   hold_done;

  secded_in_if  req_ch ();
  secded_out_if rsp_ch ();

  secded_64bit_encode_check_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  secded_64bit_encode_check_checker ecc_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off once the pipeline is busy, and a
  // window where it never stalls.
  initial begin
    hold_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && words_sent >= 150) begin
        hold_done = 1'b1;
        hold_left = 80;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= (words_sent >= 250 && words_sent < 330) ||
                        ($urandom_range(99) >= 17);
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input op_e op, input logic [DATA_W-1:0] w,
                           input logic [CHECK_W-1:0] stored);
    while (!(words_sent >= 200 && words_sent < 300) && $urandom_range(99) < 17) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.data_word <= w;
    req_ch.check_in  <= stored;
    do @(posedge clk); while (!req_ch.ready);
    words_sent++;
  endtask

  // Check words built from a good code plus a chosen damage pattern.
  task automatic send_damaged(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] data_err,
                              input logic [CHECK_W-1:0] check_err);
    send_word(OP_CHECK, w ^ data_err, ecc_chk.code_of(w) ^ check_err);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (open_count != 0);
  endtask

  initial begin
    logic [DATA_W-1:0] w;
    int                a;
    int                b;
    rst = 1'b1;
    cycle_count = 0;
    words_sent = 0;
    req_ch.valid     <= 1'b0;
    req_ch.op        <= OP_ENCODE;
    req_ch.data_word <= '0;
    req_ch.check_in  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: field extremes, both operations, clean words, every check
    // bit flip, data flips including ones aliasing a check bit flip, a bad check
    // byte and a double error that set the sticky fault, then two plain words.
    send_word(OP_ENCODE, '0, 8'hFF);
    send_word(OP_ENCODE, '1, '0);
    send_word(OP_ENCODE, 64'h8000_0000_0000_0000, CHECK_W'($urandom_range(255)));
    send_word(OP_ENCODE, rand_word(), CHECK_W'($urandom_range(255)));
    send_damaged('0, '0, '0);
    send_damaged('1, '0, '0);
    send_damaged(rand_word(), '0, '0);
    for (int k = 0; k < CHECK_W; k++) send_damaged(rand_word(), '0, 8'(1 << k));
    send_damaged(rand_word(), 64'd1, '0);
    send_damaged(rand_word(), 64'd1 << 31, '0);
    send_damaged(rand_word(), 64'd1 << 62, '0);
    send_damaged(rand_word(), 64'd1 << 63, '0);
    send_word(OP_CHECK, '0, 8'hFF);
    send_damaged(rand_word(), (64'd1 << 3) | (64'd1 << 40), '0);
    send_word(OP_ENCODE, rand_word(), '0);
    send_damaged('1, '0, '0);

    for (int n = 0; n < RandomWords; n++) begin
      if (n == 400) begin
        req_ch.valid <= 1'b0;
        wait_drained();
      end
      w = rand_word();
      a = $urandom_range(63);
      b = $urandom_range(63);
      if ($urandom_range(99) < 20) begin
        send_word(OP_ENCODE, w, CHECK_W'($urandom_range(255)));
      end else begin
        case ($urandom_range(9))
          0, 1, 2: send_damaged(w, '0, '0);
          3:       send_damaged(w, '0, 8'(1 << $urandom_range(7)));
          4, 5, 6: send_damaged(w, 64'd1 << a, '0);
          7:       send_damaged(w, (64'd1 << a) | (64'd1 << b), '0);
          8:       send_damaged(w, 64'd1 << a, 8'(1 << $urandom_range(7)));
          default: send_word(OP_CHECK, w, CHECK_W'($urandom_range(255)));
        endcase
      end
    end
    req_ch.valid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/secded_pkg.sv
rtl/core/secded_in_if.sv
rtl/core/secded_out_if.sv
rtl/core/secded_syndrome.sv
rtl/core/secded_decode.sv
rtl/core/secded_64bit_encode_check_core.sv
tb/sv/secded_64bit_encode_check_checker.sv
tb/sv/secded_64bit_encode_check_core_test.sv
